FILE: design/spt_pkg.sv
// Shared sizes, row and request types, status codes and counter helpers
// for the signature partition table. No dependencies.
package spt_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int MAX_KEY_LEN   = 8;
    localparam int KEY_WIDTH     = 32;

    localparam int IN_W     = 32;
    localparam int ELEM_W   = (KEY_WIDTH < IN_W) ? KEY_WIDTH : IN_W;
    localparam int ADDR_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ECNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int LEN_W    = $clog2(MAX_KEY_LEN + 1);
    localparam int KIDX_W   = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam int CTR_W    = 32;
    localparam int STATUS_W = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND      = 3'd0,
        ST_NEW_STORED = 3'd1,
        ST_NEW_FULL   = 3'd2,
        ST_TOO_LONG   = 3'd3,
        ST_FLUSHED    = 3'd4
    } status_t;

    typedef logic [ELEM_W-1:0] elem_t;

    typedef struct packed {
        logic [CTR_W-1:0]             id;
        logic [LEN_W-1:0]             len;
        elem_t [MAX_KEY_LEN-1:0]      keys;
    } row_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        row_t              wrow;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        status_t          status;
        logic [CTR_W-1:0] id;
        logic [CTR_W-1:0] total;
        logic [CTR_W-1:0] lmax;
        logic [CTR_W-1:0] assigned;
    } result_t;

    function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] a);
        logic [CTR_W:0] s;
        s = {1'b0, a} + {{CTR_W{1'b0}}, 1'b1};
        return s[CTR_W] ? {CTR_W{1'b1}} : s[CTR_W-1:0];
    endfunction

    function automatic logic [CTR_W-1:0] sat_add(input logic [CTR_W-1:0] a,
                                                 input logic [CTR_W-1:0] b);
        logic [CTR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CTR_W] ? {CTR_W{1'b1}} : s[CTR_W-1:0];
    endfunction

endpackage

FILE: design/signature_partition_table.sv
// Signature partition table top level: sequencer plus output register.
// Depends on spt_pkg, spt_ctrl.
//
//  channel | dir | beat contents
//  s_      | in  | tdata: key_value[31:0]; tuser: action; tlast: last
//  m_      | out | tdata: part_number, collisions_total, local_collisions_max,
//          |     |        partitions_assigned; tuser: status
//
// A closing element scans the table one entry per cycle through the table
// memory read port. A flush or an overlong key goes straight to its result
// with no scan. Reset clears all counters and empties the table at once.
// A stalled m_ side holds one result and lets the next item be worked.
module signature_partition_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // key_value[31:0]
    input  logic                          s_tuser,   // action
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [127:0]                  m_tdata,   // part_number[31:0],
                                                     // collisions_total[63:32],
                                                     // local_collisions_max[95:64],
                                                     // partitions_assigned[127:96]
    output logic [spt_pkg::STATUS_W-1:0]  m_tuser    // status
);
    import spt_pkg::*;

    logic    res_valid;
    logic    res_ready;
    result_t res;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [127:0]          m_tdata_reg;
    logic [STATUS_W-1:0]   m_tuser_reg;

    spt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_value  (s_tdata),
        .in_last   (s_tlast),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_tdata_reg <= {res.assigned, res.lmax, res.total, res.id};
            m_tuser_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: design/spt_table_ram.sv
// Table store: one row per entry (partition id, key length, key elements).
// Simple dual port, registered read. Depends on spt_pkg.
module spt_table_ram (
    input  logic              aclk,
    input  spt_pkg::ram_req_t req,
    output spt_pkg::row_t     rd_row
);
    import spt_pkg::*;

    row_t mem [TABLE_ENTRIES];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wrow;
        end
        if (req.re) begin
            rd_row <= mem[req.raddr];
        end
    end

endmodule

FILE: design/spt_match.sv
// Compares one table row against the open key: same length, same elements.
// Depends on spt_pkg.
module spt_match (
    input  spt_pkg::row_t                          row,
    input  spt_pkg::elem_t [spt_pkg::MAX_KEY_LEN-1:0] kbuf,
    input  logic [spt_pkg::LEN_W-1:0]              len,
    output logic                                   hit
);
    import spt_pkg::*;

    logic [MAX_KEY_LEN-1:0] elem_ok;

    always_comb begin
        for (int j = 0; j < MAX_KEY_LEN; j++) begin
            elem_ok[j] = (LEN_W'(j) >= len) || (row.keys[j] == kbuf[j]);
        end
    end

    assign hit = (row.len == len) && (&elem_ok);

endmodule

FILE: design/spt_ctrl.sv
// Sequencer: key assembly, linear table search, insert and flush, counters.
// Depends on spt_pkg, spt_table_ram, spt_match.
module spt_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    in_action,
    input  logic [spt_pkg::IN_W-1:0] in_value,
    input  logic                    in_last,
    output logic                    res_valid,
    input  logic                    res_ready,
    output spt_pkg::result_t        res
);
    import spt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_RESULT = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    elem_t [MAX_KEY_LEN-1:0] kbuf_reg, kbuf_next;
    logic [LEN_W-1:0]        kcnt_reg, kcnt_next;
    logic                    ovf_reg, ovf_next;
    logic [ECNT_W-1:0]       ecnt_reg, ecnt_next;
    logic [ECNT_W-1:0]       scan_reg, scan_next;
    logic                    pend_reg, pend_next;
    logic [CTR_W-1:0]        npart_reg, npart_next;
    logic [CTR_W-1:0]        local_reg, local_next;
    logic [CTR_W-1:0]        total_reg, total_next;
    logic [CTR_W-1:0]        lmax_reg, lmax_next;
    status_t                 status_reg, status_next;
    logic [CTR_W-1:0]        id_reg, id_next;

    ram_req_t req;
    row_t     rd_row;
    logic     hit;
    logic     issue;
    logic     do_new;

    spt_table_ram u_ram (
        .aclk   (aclk),
        .req    (req),
        .rd_row (rd_row)
    );

    spt_match u_match (
        .row  (rd_row),
        .kbuf (kbuf_reg),
        .len  (kcnt_reg),
        .hit  (hit)
    );

    always_comb begin
        state_next  = state_reg;
        kbuf_next   = kbuf_reg;
        kcnt_next   = kcnt_reg;
        ovf_next    = ovf_reg;
        ecnt_next   = ecnt_reg;
        scan_next   = scan_reg;
        pend_next   = pend_reg;
        npart_next  = npart_reg;
        local_next  = local_reg;
        total_next  = total_reg;
        lmax_next   = lmax_reg;
        status_next = status_reg;
        id_next     = id_reg;
        req         = '0;
        issue       = 1'b0;
        do_new      = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    if (in_action) begin
                        if (local_reg > lmax_reg) begin
                            lmax_next = local_reg;
                        end
                        total_next  = sat_add(total_reg, local_reg);
                        local_next  = '0;
                        ecnt_next   = '0;
                        kcnt_next   = '0;
                        ovf_next    = 1'b0;
                        status_next = ST_FLUSHED;
                        id_next     = '0;
                        state_next  = S_RESULT;
                    end else begin
                        if (kcnt_reg < LEN_W'(MAX_KEY_LEN)) begin
                            kbuf_next[kcnt_reg[KIDX_W-1:0]] = in_value[ELEM_W-1:0];
                            kcnt_next = kcnt_reg + 1'b1;
                        end else begin
                            ovf_next = 1'b1;
                        end
                        if (in_last) begin
                            if (ovf_next) begin
                                status_next = ST_TOO_LONG;
                                id_next     = '0;
                                kcnt_next   = '0;
                                ovf_next    = 1'b0;
                                state_next  = S_RESULT;
                            end else if (ecnt_reg == '0) begin
                                do_new = 1'b1;
                            end else begin
                                scan_next  = '0;
                                pend_next  = 1'b0;
                                state_next = S_SEARCH;
                            end
                        end
                    end
                end
            end
            S_SEARCH: begin
                issue     = scan_reg < ecnt_reg;
                req.re    = issue;
                req.raddr = scan_reg[ADDR_W-1:0];
                scan_next = scan_reg + ECNT_W'(issue);
                pend_next = issue;
                if (pend_reg && hit) begin
                    status_next = ST_FOUND;
                    id_next     = rd_row.id;
                    kcnt_next   = '0;
                    ovf_next    = 1'b0;
                    pend_next   = 1'b0;
                    state_next  = S_RESULT;
                end else if (pend_reg && !issue) begin
                    do_new = 1'b1;
                end
            end
            S_RESULT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (do_new) begin
            if (ecnt_reg != '0) begin
                local_next = sat_inc(local_reg);
            end
            id_next    = npart_reg;
            npart_next = sat_inc(npart_reg);
            if (ecnt_reg < ECNT_W'(TABLE_ENTRIES)) begin
                req.we        = 1'b1;
                req.waddr     = ecnt_reg[ADDR_W-1:0];
                req.wrow.id   = npart_reg;
                req.wrow.len  = kcnt_next;
                req.wrow.keys = kbuf_next;
                ecnt_next     = ecnt_reg + 1'b1;
                status_next   = ST_NEW_STORED;
            end else begin
                status_next   = ST_NEW_FULL;
            end
            kcnt_next  = '0;
            ovf_next   = 1'b0;
            pend_next  = 1'b0;
            state_next = S_RESULT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            kcnt_reg  <= '0;
            ovf_reg   <= 1'b0;
            ecnt_reg  <= '0;
            scan_reg  <= '0;
            pend_reg  <= 1'b0;
            npart_reg <= '0;
            local_reg <= '0;
            total_reg <= '0;
            lmax_reg  <= '0;
        end else begin
            state_reg <= state_next;
            kcnt_reg  <= kcnt_next;
            ovf_reg   <= ovf_next;
            ecnt_reg  <= ecnt_next;
            scan_reg  <= scan_next;
            pend_reg  <= pend_next;
            npart_reg <= npart_next;
            local_reg <= local_next;
            total_reg <= total_next;
            lmax_reg  <= lmax_next;
        end
    end

    always_ff @(posedge aclk) begin
        kbuf_reg   <= kbuf_next;
        status_reg <= status_next;
        id_reg     <= id_next;
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign res_valid    = (state_reg == S_RESULT);
    assign res.status   = status_reg;
    assign res.id       = id_reg;
    assign res.total    = total_reg;
    assign res.lmax     = lmax_reg;
    assign res.assigned = npart_reg;

endmodule

FILE: design/spt_checker.sv
// Port-level checks for the signature partition table, bound to the top.
// Depends on spt_pkg and signature_partition_table.
module spt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [31:0]                   s_tdata,
    input logic                          s_tuser,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [127:0]                  m_tdata,
    input logic [spt_pkg::STATUS_W-1:0]  m_tuser
);
    import spt_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_no_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_FLUSHED || m_tuser == ST_TOO_LONG)
        |-> m_tdata[31:0] == '0)
        else $error("flush or overlong result carries a partition number");

    a_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_NEW_STORED || m_tuser == ST_NEW_FULL)
        |-> (m_tdata[127:96] == m_tdata[31:0] + 32'd1) || (m_tdata[31:0] == '1))
        else $error("issued id and assigned count disagree");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat straight after reset");

endmodule

bind signature_partition_table spt_checker u_spt_checker (.*);

FILE: verif/tb_signature_partition_table.sv
// Self-checking testbench for signature_partition_table: directed and random key
// streams, table fill and flushes, checked beat by beat against a built-in predictor.
// Depends on spt_pkg and the signature_partition_table RTL.
`timescale 1ns / 1ps

module tb_signature_partition_table;
    import spt_pkg::*;

    localparam logic        ACT_KEY     = 1'b0;
    localparam logic        ACT_FLUSH   = 1'b1;
    localparam int unsigned KEY_SLOTS   = MAX_KEY_LEN + 3;
    localparam int unsigned SAVED_SLOTS = 16;
    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN       = 20;
    localparam logic [CTR_W-1:0] CTR_TOP = '1;

    class partition_scoreboard;
        elem_t            open_key[MAX_KEY_LEN];
        int unsigned      open_len;
        bit               open_too_long;
        elem_t            row_keys[TABLE_ENTRIES][MAX_KEY_LEN];
        int unsigned      row_len[TABLE_ENTRIES];
        logic [CTR_W-1:0] row_id[TABLE_ENTRIES];
        int unsigned      rows;
        logic [CTR_W-1:0] issued;
        logic [CTR_W-1:0] local_coll;
        logic [CTR_W-1:0] total_coll;
        logic [CTR_W-1:0] local_peak;
        result_t          awaited[$];
        int unsigned      beats;
        int unsigned      checked;
        int unsigned      fails;
        int unsigned      kind_seen[8];

        function new();
            open_len      = 0;
            open_too_long = 0;
            rows          = 0;
            issued        = '0;
            local_coll    = '0;
            total_coll    = '0;
            local_peak    = '0;
            beats         = 0;
            checked       = 0;
            fails         = 0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
        endfunction

        function logic [CTR_W-1:0] capped_sum(logic [CTR_W-1:0] a, logic [CTR_W-1:0] b);
            if (a > CTR_TOP - b) return CTR_TOP;
            return a + b;
        endfunction

        function bit row_matches(int unsigned e);
            if (row_len[e] != open_len) return 0;
            for (int unsigned j = 0; j < open_len; j++) begin
                if (row_keys[e][j] != open_key[j]) return 0;
            end
            return 1;
        endfunction

        task report_mismatch(string what);
            $display("mismatch @%0t: %s", $time, what);
            fails++;
        endtask

        function void note_beat(logic act, elem_t val, logic lst);
            result_t exp;
            bit      hit;
            exp = '0;
            hit = 0;
            beats++;
            if (act == ACT_FLUSH) begin
                if (local_coll > local_peak) local_peak = local_coll;
                total_coll    = capped_sum(total_coll, local_coll);
                local_coll    = '0;
                rows          = 0;
                open_len      = 0;
                open_too_long = 0;
                exp.status    = ST_FLUSHED;
            end else begin
                if (open_len < MAX_KEY_LEN) begin
                    open_key[open_len] = val;
                    open_len++;
                end else begin
                    open_too_long = 1;
                end
                if (!lst) return;
                if (open_too_long) begin
                    exp.status = ST_TOO_LONG;
                end else begin
                    for (int unsigned e = 0; e < rows && !hit; e++) begin
                        if (row_matches(e)) begin
                            hit    = 1;
                            exp.id = row_id[e];
                        end
                    end
                    if (hit) begin
                        exp.status = ST_FOUND;
                    end else begin
                        if (rows != 0) local_coll = capped_sum(local_coll, 1);
                        exp.id = issued;
                        issued = capped_sum(issued, 1);
                        if (rows < TABLE_ENTRIES) begin
                            for (int unsigned j = 0; j < open_len; j++)
                                row_keys[rows][j] = open_key[j];
                            row_len[rows] = open_len;
                            row_id[rows]  = exp.id;
                            rows++;
                            exp.status = ST_NEW_STORED;
                        end else begin
                            exp.status = ST_NEW_FULL;
                        end
                    end
                end
                open_len      = 0;
                open_too_long = 0;
            end
            exp.total    = total_coll;
            exp.lmax     = local_peak;
            exp.assigned = issued;
            kind_seen[exp.status]++;
            awaited.insert(awaited.size(), exp);
        endfunction

        task check_result(logic [STATUS_W-1:0] st, logic [127:0] data);
            result_t exp;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("unexpected result, status %0d id %0h", st,
                                          data[31:0]));
                return;
            end
            exp = awaited.pop_front();
            checked++;
            if (st !== exp.status)
                report_mismatch($sformatf("status %0d, want %0d", st, exp.status));
            if (data[31:0] !== exp.id)
                report_mismatch($sformatf("part_number %0h, want %0h", data[31:0], exp.id));
            if (data[63:32] !== exp.total)
                report_mismatch($sformatf("collisions_total %0d, want %0d", data[63:32],
                                          exp.total));
            if (data[95:64] !== exp.lmax)
                report_mismatch($sformatf("local_collisions_max %0d, want %0d", data[95:64],
                                          exp.lmax));
            if (data[127:96] !== exp.assigned)
                report_mismatch($sformatf("partitions_assigned %0d, want %0d", data[127:96],
                                          exp.assigned));
        endtask
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata  = '0;   // key_value[31:0]
    logic                s_tuser  = 1'b0; // action
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [127:0]        m_tdata;         // part_number, collisions_total,
                                          // local_collisions_max, partitions_assigned
    logic [STATUS_W-1:0] m_tuser;         // status

    partition_scoreboard sb = new();

    int unsigned src_idle  = 14;
    int unsigned dst_idle  = 80;
    bit          hold_req  = 0;
    int unsigned hold_left = 0;
    int unsigned quiet     = 0;

    elem_t       saved_keys[SAVED_SLOTS][KEY_SLOTS];
    int unsigned saved_len[SAVED_SLOTS];
    int unsigned saved_count = 0;

    signature_partition_table u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // result side: random back-pressure, long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= dst_idle);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_beat(input logic act, input elem_t val, input logic lst);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= val;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_beat(act, val, lst);
    endtask

    task automatic send_key(input elem_t elems[KEY_SLOTS], input int unsigned len);
        for (int unsigned i = 0; i < len; i++) send_beat(ACT_KEY, elems[i], i == len - 1);
    endtask

    task automatic send_flush();
        send_beat(ACT_FLUSH, elem_t'($urandom), 1'($urandom));
    endtask

    function automatic elem_t pick_element();
        case ($urandom_range(3))
            0:       return elem_t'($urandom_range(3));
            1:       return elem_t'($urandom);
            2:       return ~elem_t'($urandom_range(3));
            default: return elem_t'(1) << $urandom_range(ELEM_W - 1);
        endcase
    endfunction

    task automatic run_directed();
        elem_t k[KEY_SLOTS];
        foreach (k[i]) k[i] = '0;
        send_beat(ACT_FLUSH, '0, 1'b0);                      // flush of an empty table
        send_key(k, 1);                                      // all-zero element
        k[0] = '1;
        send_key(k, 1);                                      // all-ones element, first collision
        k[0] = '0;
        send_key(k, 1);                                      // hit
        k[0] = 32'd5;
        k[1] = 32'd7;
        send_key(k, 2);
        send_key(k, 1);                                      // prefix of a stored key: new
        foreach (k[i]) k[i] = i[0] ? '1 : 32'h5A5A_A5A5 ^ elem_t'(i);
        send_key(k, MAX_KEY_LEN);                            // longest legal key
        send_key(k, MAX_KEY_LEN + 1);                        // one element too many
        k[0] = 32'd3;
        send_key(k, 1);
        send_beat(ACT_KEY, 32'd3, 1'b0);                     // open key cut by flush
        send_beat(ACT_FLUSH, '1, 1'b1);
        send_key(k, 1);
    endtask

    task automatic run_random(input int unsigned n_items);
        elem_t       k[KEY_SLOTS];
        int unsigned sent;
        int unsigned r;
        int unsigned len;
        int unsigned slot;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 6) begin
                send_flush();
                sent++;
            end else if (r < 10) begin
                len = $urandom_range(1, 4);
                for (int unsigned i = 0; i < len; i++) send_beat(ACT_KEY, pick_element(), 1'b0);
                send_flush();
                sent += len + 1;
            end else if (saved_count != 0 && r < 45) begin
                slot = $urandom_range(saved_count - 1);
                send_key(saved_keys[slot], saved_len[slot]);
                sent += saved_len[slot];
            end else begin
                len = (r < 15) ? $urandom_range(MAX_KEY_LEN + 1, KEY_SLOTS)
                               : $urandom_range(1, MAX_KEY_LEN);
                foreach (k[i]) k[i] = pick_element();
                send_key(k, len);
                sent += len;
                slot = (saved_count < SAVED_SLOTS) ? saved_count : $urandom_range(SAVED_SLOTS - 1);
                if (saved_count < SAVED_SLOTS) saved_count++;
                saved_keys[slot] = k;
                saved_len[slot]  = len;
            end
        end
    endtask

    // fills the table past capacity with distinct one-element keys
    task automatic run_fill();
        elem_t k[KEY_SLOTS];
        elem_t first_val;
        elem_t mid_val;
        foreach (k[i]) k[i] = '0;
        first_val = '0;
        mid_val   = '0;
        send_flush();
        for (int unsigned i = 0; i < TABLE_ENTRIES + 6; i++) begin
            k[0] = (elem_t'($urandom) << 12) | elem_t'(i);
            if (i == 0) first_val = k[0];
            if (i == TABLE_ENTRIES - 1) mid_val = k[0];
            send_key(k, 1);
        end
        k[0] = mid_val;
        send_key(k, 1);
        k[0] = first_val;
        send_key(k, 1);
        send_flush();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle = 14;
        dst_idle = 80;
        run_directed();
        run_random(240);

        src_idle = 80;
        dst_idle = 14;
        run_random(240);

        src_idle = 0;
        dst_idle = 0;
        run_fill();
        hold_req = 1;
        run_random(60);
        s_tvalid <= 1'b0;

        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        $display("run: %0d beats in, %0d results checked, %0d mismatches",
                 sb.beats, sb.checked, sb.fails);
        $display("kinds: found %0d, stored %0d, table full %0d, overlong %0d, flushed %0d",
                 sb.kind_seen[ST_FOUND], sb.kind_seen[ST_NEW_STORED], sb.kind_seen[ST_NEW_FULL],
                 sb.kind_seen[ST_TOO_LONG], sb.kind_seen[ST_FLUSHED]);
        if (sb.fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
